>>> sv/via_pkg.sv
// Package for the versatile interface adapter: event kinds, register
// selects, interrupt flag bit positions and the controller/datapath structs.
// No dependencies.
`default_nettype none
package via_pkg;

   typedef enum logic [1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_TICK  = 2'd2,
      FUNC_LINE  = 2'd3
   } func_type;

   localparam logic [3:0] REG_ORB   = 4'h0;
   localparam logic [3:0] REG_ORA   = 4'h1;
   localparam logic [3:0] REG_DDRB  = 4'h2;
   localparam logic [3:0] REG_DDRA  = 4'h3;
   localparam logic [3:0] REG_T1CL  = 4'h4;
   localparam logic [3:0] REG_T1CH  = 4'h5;
   localparam logic [3:0] REG_T1LL  = 4'h6;
   localparam logic [3:0] REG_T1LH  = 4'h7;
   localparam logic [3:0] REG_T2CL  = 4'h8;
   localparam logic [3:0] REG_T2CH  = 4'h9;
   localparam logic [3:0] REG_SR    = 4'hA;
   localparam logic [3:0] REG_ACR   = 4'hB;
   localparam logic [3:0] REG_PCR   = 4'hC;
   localparam logic [3:0] REG_IFR   = 4'hD;
   localparam logic [3:0] REG_IER   = 4'hE;
   localparam logic [3:0] REG_ORA_NH = 4'hF;

   localparam int FLAG_CA2 = 0;
   localparam int FLAG_CA1 = 1;
   localparam int FLAG_CB2 = 3;
   localparam int FLAG_CB1 = 4;
   localparam int FLAG_T2  = 5;
   localparam int FLAG_T1  = 6;

   localparam int CNT_W = 18;

   // controller -> datapath
   typedef struct packed {
      logic exec;     // apply the held event to the registers
      logic t1_step;  // add one timer 1 period
      logic t1_done;  // reload finished, apply timer 1 side effects
      logic load;     // capture a new event
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic t1_needs_reload; // count below -3 after a tick
      logic t1_settled;      // count at least -1 after a period add
   } dp_sts_type;

endpackage
`default_nettype wire

>>> sv/via_ctrl.sv
// Controller for the interface adapter: sequences load, execute, the
// timer 1 reload loop and the result beat. Uses via_pkg.
`default_nettype none
module via_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   input  wire via_pkg::func_type   func,
   output via_pkg::dp_cmd_type      cmd,
   input  wire via_pkg::dp_sts_type sts
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_EXEC   = 6'b000010,
      ST_CHECK  = 6'b000100,
      ST_RELOAD = 6'b001000,
      ST_FINISH = 6'b010000,
      ST_OUT    = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (func == via_pkg::FUNC_TICK) state_in = ST_CHECK;
            else state_in = ST_OUT;
         end
         // count after the tick decides whether timer 1 reloads at all
         ST_CHECK: begin
            if (sts.t1_needs_reload) begin
               cmd.t1_step = 1'b1;
               state_in = ST_RELOAD;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_RELOAD: begin
            if (sts.t1_settled) state_in = ST_FINISH;
            else cmd.t1_step = 1'b1;
         end
         ST_FINISH: begin
            cmd.t1_done = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

endmodule
`default_nettype wire

>>> sv/via_dp.sv
// Datapath for the interface adapter: port, timer, control and interrupt
// registers with their bus side effects. Uses via_pkg.
`default_nettype none
module via_dp (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire via_pkg::dp_cmd_type cmd,
   output via_pkg::dp_sts_type      sts,
   input  wire logic [1:0]          func,
   input  wire logic [3:0]          addr,
   input  wire logic [7:0]          wdata,
   input  wire logic [11:0]         elapsed,
   input  wire logic [1:0]          line_sel,
   input  wire logic                line_level,
   input  wire logic [7:0]          pins_a,
   input  wire logic [7:0]          pins_b,
   output logic [7:0]               rdata,
   output logic                     irq,
   output logic [7:0]               drive_a,
   output logic [7:0]               drive_b,
   output logic                     ca2_out,
   output logic                     cb2_out,
   output logic                     ca2_strobe,
   output logic                     cb2_strobe
);

   localparam int W = via_pkg::CNT_W;
   localparam logic signed [W-1:0] CNT_M1 = -W'(1);
   localparam logic signed [W-1:0] CNT_M3 = -W'(3);

   // held event
   logic [1:0]  func_ff;
   logic [3:0]  addr_ff;
   logic [7:0]  wdata_ff, pa_ff, pb_ff;
   logic [11:0] elapsed_ff;
   logic [1:0]  sel_ff;
   logic        lv_ff;

   logic [7:0] out_a_ff, out_b_ff, dir_a_ff, dir_b_ff, lat_a_ff, lat_b_ff;
   logic signed [W-1:0] cnt1_ff, cnt2_ff;
   logic [15:0] rl1_ff, rl2_ff;
   logic done1_ff, done2_ff;
   logic [7:0] acr_ff, pcr_ff, ifr_ff, sr_ff;
   logic [6:0] ier_ff;
   logic [3:0] lines_ff;
   logic [7:0] rdata_ff;
   logic sa_ff, sb_ff;

   logic [7:0] out_a_in, out_b_in, dir_a_in, dir_b_in, lat_a_in, lat_b_in;
   logic signed [W-1:0] cnt1_in, cnt2_in;
   logic [15:0] rl1_in, rl2_in;
   logic done1_in, done2_in;
   logic [7:0] acr_in, pcr_in, ifr_in, sr_in, rdata_in;
   logic [6:0] ier_in;
   logic [3:0] lines_in;
   logic sa_in, sb_in;

   logic signed [W-1:0] per1, cnt1_step;
   logic [7:0] src, flags;

   assign per1      = W'(rl1_ff) + W'(2);
   assign cnt1_step = cnt1_ff + per1;
   assign sts.t1_needs_reload = cnt1_ff < CNT_M3;
   assign sts.t1_settled      = cnt1_ff >= CNT_M1;

   always_comb begin
      out_a_in = out_a_ff; out_b_in = out_b_ff;
      dir_a_in = dir_a_ff; dir_b_in = dir_b_ff;
      lat_a_in = lat_a_ff; lat_b_in = lat_b_ff;
      cnt1_in = cnt1_ff; cnt2_in = cnt2_ff;
      rl1_in = rl1_ff; rl2_in = rl2_ff;
      done1_in = done1_ff; done2_in = done2_ff;
      acr_in = acr_ff; pcr_in = pcr_ff; sr_in = sr_ff; ier_in = ier_ff;
      lines_in = lines_ff;
      rdata_in = rdata_ff; sa_in = sa_ff; sb_in = sb_ff;
      flags = ifr_ff;
      src = 8'h00;
      if (cmd.load) begin
         rdata_in = 8'h00; sa_in = 1'b0; sb_in = 1'b0;
      end
      if (cmd.t1_step) cnt1_in = cnt1_step;
      if (cmd.t1_done) begin
         if (!done1_ff) flags[via_pkg::FLAG_T1] = 1'b1;
         if (acr_ff[7] && !done1_ff) out_b_in[7] = ~out_b_ff[7];
         if (!acr_ff[6]) done1_in = 1'b1;
      end
      if (cmd.exec) begin
         unique case (via_pkg::func_type'(func_ff))
            via_pkg::FUNC_WRITE: begin
               unique case (addr_ff)
                  via_pkg::REG_ORB: begin
                     flags[via_pkg::FLAG_CB1] = 1'b0;
                     if ((pcr_ff & 8'hA0) != 8'h20) flags[via_pkg::FLAG_CB2] = 1'b0;
                     out_b_in = wdata_ff;
                     if ((pcr_ff & 8'hE0) == 8'h80) lines_in[3] = 1'b0;
                     if ((pcr_ff & 8'hE0) == 8'hA0) begin
                        sb_in = 1'b1; lines_in[3] = 1'b1;
                     end
                  end
                  via_pkg::REG_ORA: begin
                     flags[via_pkg::FLAG_CA1] = 1'b0;
                     if ((pcr_ff & 8'h0A) != 8'h02) flags[via_pkg::FLAG_CA2] = 1'b0;
                     if ((pcr_ff & 8'h0E) == 8'h08) lines_in[1] = 1'b0;
                     if ((pcr_ff & 8'h0E) == 8'h0A) begin
                        sa_in = 1'b1; lines_in[1] = 1'b1;
                     end
                     out_a_in = wdata_ff;
                  end
                  via_pkg::REG_ORA_NH: out_a_in = wdata_ff;
                  via_pkg::REG_DDRB: dir_b_in = wdata_ff;
                  via_pkg::REG_DDRA: dir_a_in = wdata_ff;
                  via_pkg::REG_T1CL, via_pkg::REG_T1LL: rl1_in[7:0] = wdata_ff;
                  via_pkg::REG_T1LH: begin
                     rl1_in[15:8] = wdata_ff;
                     if (acr_ff[6]) flags[via_pkg::FLAG_T1] = 1'b0;
                  end
                  via_pkg::REG_T1CH: begin
                     if ((acr_ff & 8'hC0) == 8'h80) out_b_in[7] = 1'b0;
                     rl1_in[15:8] = wdata_ff;
                     cnt1_in = W'({wdata_ff, rl1_ff[7:0]}) + W'(1);
                     done1_in = 1'b0;
                     flags[via_pkg::FLAG_T1] = 1'b0;
                  end
                  via_pkg::REG_T2CL: rl2_in[7:0] = wdata_ff;
                  via_pkg::REG_T2CH: begin
                     rl2_in[15:8] = wdata_ff;
                     cnt2_in = W'({wdata_ff, rl2_ff[7:0]}) + W'(1);
                     flags[via_pkg::FLAG_T2] = 1'b0;
                     done2_in = 1'b0;
                  end
                  via_pkg::REG_SR: sr_in = wdata_ff;
                  via_pkg::REG_ACR: acr_in = wdata_ff;
                  via_pkg::REG_PCR: begin
                     pcr_in = wdata_ff;
                     if ((wdata_ff & 8'h0E) == 8'h0C) lines_in[1] = 1'b0;
                     else if (wdata_ff[3]) lines_in[1] = 1'b1;
                     if ((wdata_ff & 8'hE0) == 8'hC0) lines_in[3] = 1'b0;
                     else if (wdata_ff[7]) lines_in[3] = 1'b1;
                  end
                  via_pkg::REG_IFR: flags = flags & ~(wdata_ff & 8'h7F);
                  default: begin
                     if (wdata_ff[7]) ier_in = ier_ff | wdata_ff[6:0];
                     else ier_in = ier_ff & ~wdata_ff[6:0];
                  end
               endcase
            end
            via_pkg::FUNC_READ: begin
               unique case (addr_ff)
                  via_pkg::REG_ORA, via_pkg::REG_ORA_NH: begin
                     if (addr_ff == via_pkg::REG_ORA) begin
                        flags[via_pkg::FLAG_CA1] = 1'b0;
                        if ((pcr_ff & 8'h0A) != 8'h02) flags[via_pkg::FLAG_CA2] = 1'b0;
                     end
                     src = acr_ff[0] ? lat_a_ff : pa_ff;
                     rdata_in = (out_a_ff & dir_a_ff) | (src & ~dir_a_ff);
                  end
                  via_pkg::REG_ORB: begin
                     flags[via_pkg::FLAG_CB1] = 1'b0;
                     if ((pcr_ff & 8'hA0) != 8'h20) flags[via_pkg::FLAG_CB2] = 1'b0;
                     src = acr_ff[1] ? lat_b_ff : pb_ff;
                     rdata_in = (out_b_ff & dir_b_ff) | (src & ~dir_b_ff);
                  end
                  via_pkg::REG_DDRB: rdata_in = dir_b_ff;
                  via_pkg::REG_DDRA: rdata_in = dir_a_ff;
                  via_pkg::REG_T1LL: rdata_in = rl1_ff[7:0];
                  via_pkg::REG_T1LH: rdata_in = rl1_ff[15:8];
                  via_pkg::REG_T1CL: begin
                     flags[via_pkg::FLAG_T1] = 1'b0;
                     rdata_in = sts.t1_settled ? cnt1_ff[7:0] : 8'hFF;
                  end
                  via_pkg::REG_T1CH:
                     rdata_in = sts.t1_settled ? cnt1_ff[15:8] : 8'hFF;
                  via_pkg::REG_T2CL: begin
                     flags[via_pkg::FLAG_T2] = 1'b0;
                     rdata_in = cnt2_ff[7:0];
                  end
                  via_pkg::REG_T2CH: rdata_in = cnt2_ff[15:8];
                  via_pkg::REG_SR:  rdata_in = sr_ff;
                  via_pkg::REG_ACR: rdata_in = acr_ff;
                  via_pkg::REG_PCR: rdata_in = pcr_ff;
                  via_pkg::REG_IFR: rdata_in = ifr_ff;
                  default: rdata_in = {1'b1, ier_ff};
               endcase
            end
            via_pkg::FUNC_TICK: begin
               cnt1_in = cnt1_ff - W'(elapsed_ff);
               cnt2_in = cnt2_ff - W'(elapsed_ff);
               if (!acr_ff[5] && cnt2_in < CNT_M1 && !done2_ff) begin
                  flags[via_pkg::FLAG_T2] = 1'b1;
                  done2_in = 1'b1;
               end
            end
            default: begin
               if (lv_ff != lines_ff[sel_ff]) begin
                  lines_in[sel_ff] = lv_ff;
                  unique case (sel_ff)
                     2'd0: if (pcr_ff[0] == lv_ff) begin
                        if (acr_ff[0]) lat_a_in = pa_ff;
                        flags[via_pkg::FLAG_CA1] = 1'b1;
                        if ((pcr_ff & 8'h0C) == 8'h08) lines_in[1] = 1'b1;
                     end
                     2'd1: begin
                        if (pcr_ff[3]) lines_in[1] = lines_ff[1];
                        else if (pcr_ff[2] == lv_ff) flags[via_pkg::FLAG_CA2] = 1'b1;
                     end
                     2'd2: if (pcr_ff[4] == lv_ff) begin
                        if (acr_ff[1]) lat_b_in = pb_ff;
                        flags[via_pkg::FLAG_CB1] = 1'b1;
                        if ((pcr_ff & 8'hC0) == 8'h80) lines_in[3] = 1'b1;
                     end
                     default: begin
                        if (pcr_ff[7]) lines_in[3] = lines_ff[3];
                        else if (pcr_ff[6] == lv_ff) flags[via_pkg::FLAG_CB2] = 1'b1;
                     end
                  endcase
               end
            end
         endcase
      end
      flags[7] = |(flags[6:0] & ier_in);
      ifr_in = flags;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= func; addr_ff <= addr; wdata_ff <= wdata;
         elapsed_ff <= elapsed; sel_ff <= line_sel; lv_ff <= line_level;
         pa_ff <= pins_a; pb_ff <= pins_b;
      end
      if (reset) begin
         out_a_ff <= 8'hFF; out_b_ff <= 8'hFF; dir_a_ff <= 8'hFF; dir_b_ff <= 8'hFF;
         lat_a_ff <= '0; lat_b_ff <= '0;
         cnt1_ff <= W'(16'hFFFF); cnt2_ff <= W'(16'hFFFF);
         rl1_ff <= 16'hFFFF; rl2_ff <= 16'hFFFF;
         done1_ff <= 1'b1; done2_ff <= 1'b1;
         acr_ff <= '0; pcr_ff <= '0; ifr_ff <= '0; ier_ff <= '0; sr_ff <= '0;
         lines_ff <= '0; rdata_ff <= '0; sa_ff <= 1'b0; sb_ff <= 1'b0;
      end else begin
         out_a_ff <= out_a_in; out_b_ff <= out_b_in;
         dir_a_ff <= dir_a_in; dir_b_ff <= dir_b_in;
         lat_a_ff <= lat_a_in; lat_b_ff <= lat_b_in;
         cnt1_ff <= cnt1_in; cnt2_ff <= cnt2_in;
         rl1_ff <= rl1_in; rl2_ff <= rl2_in;
         done1_ff <= done1_in; done2_ff <= done2_in;
         acr_ff <= acr_in; pcr_ff <= pcr_in; ifr_ff <= ifr_in;
         ier_ff <= ier_in; sr_ff <= sr_in; lines_ff <= lines_in;
         rdata_ff <= rdata_in; sa_ff <= sa_in; sb_ff <= sb_in;
      end
   end

   assign rdata      = rdata_ff;
   assign irq        = ifr_ff[7];
   assign drive_a    = (out_a_ff & dir_a_ff) | ~dir_a_ff;
   assign drive_b    = (out_b_ff & dir_b_ff) | ~dir_b_ff;
   assign ca2_out    = lines_ff[1];
   assign cb2_out    = lines_ff[3];
   assign ca2_strobe = sa_ff;
   assign cb2_strobe = sb_ff;

endmodule
`default_nettype wire

>>> sv/versatile_interface_adapter.sv
// Top level of the versatile interface adapter (6522-style).
// Instantiates via_ctrl and via_dp; uses via_pkg.
//
// Usage:
//  - req channel: one beat is one event: bus write, bus read, elapsed
//    timer ticks, or a level change on CA1/CA2/CB1/CB2.
//  - rsp channel: one beat per request: read data (zero unless a read),
//    IRQ, port drives, CA2/CB2 levels and pulse strobes.
//  - Sequencing: a write, read or line event goes from accept through
//    EXEC to OUT (rsp_tvalid). A tick also passes CHECK and, when timer 1
//    underflows, RELOAD, adding one timer 1 period per step until the count
//    settles, then FINISH (k = ceil((-1 - count) / (latch + 2)) periods).
//  - One event at a time: req_tready is high only while idle, so a new
//    event is taken only after the previous result beat is accepted.
//  - rsp stall: the result beat holds until rsp_tready; no new request
//    is taken meanwhile.
//  - reset (synchronous, active high): ports and directions 0xFF,
//    timers 0xFFFF and expired, control and interrupt registers zero.
`default_nettype none
module versatile_interface_adapter (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // func[1:0], addr[5:2], wdata[13:6], elapsed[25:14], pins_a[33:26],
   // pins_b[41:34], pad
   input  wire logic [47:0] req_tdata,
   // line_sel[1:0], line_level[2]
   input  wire logic [2:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // rdata[7:0], drive_a[15:8], drive_b[23:16]
   output logic [23:0]      rsp_tdata,
   // irq[0], ca2_out[1], cb2_out[2], ca2_strobe[3], cb2_strobe[4]
   output logic [4:0]       rsp_tuser
);

   via_pkg::dp_cmd_type cmd;
   via_pkg::dp_sts_type sts;
   logic [1:0] func_held;

   // the controller branches on the held event kind, captured here on load as in the datapath
   logic [1:0] func_ff;
   always_ff @(posedge clock) begin
      if (cmd.load) func_ff <= req_tdata[1:0];
   end
   assign func_held = func_ff;

   via_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .func       (via_pkg::func_type'(func_held)),
      .cmd        (cmd),
      .sts        (sts)
   );

   via_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .func       (req_tdata[1:0]),
      .addr       (req_tdata[5:2]),
      .wdata      (req_tdata[13:6]),
      .elapsed    (req_tdata[25:14]),
      .line_sel   (req_tuser[1:0]),
      .line_level (req_tuser[2]),
      .pins_a     (req_tdata[33:26]),
      .pins_b     (req_tdata[41:34]),
      .rdata      (rsp_tdata[7:0]),
      .irq        (rsp_tuser[0]),
      .drive_a    (rsp_tdata[15:8]),
      .drive_b    (rsp_tdata[23:16]),
      .ca2_out    (rsp_tuser[1]),
      .cb2_out    (rsp_tuser[2]),
      .ca2_strobe (rsp_tuser[3]),
      .cb2_strobe (rsp_tuser[4])
   );

endmodule
`default_nettype wire

>>> dv/versatile_interface_adapter_tb.sv
// Self-checking testbench for the 6522-style interface adapter: bus writes,
// reads, timer ticks and control line events, checked against an in-bench model.
// Depends on via_pkg and versatile_interface_adapter.
`default_nettype none
module versatile_interface_adapter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [4:0]  rsp_tuser;

   versatile_interface_adapter dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Shadow copy of the adapter's registers
   // ---------------------------------------------------------------------
   logic [7:0]  m_out_a, m_out_b, m_dir_a, m_dir_b, m_lat_a, m_lat_b;
   int          m_cnt1, m_cnt2;
   logic [15:0] m_rel1, m_rel2;
   bit          m_done1, m_done2;
   logic [7:0]  m_acr, m_pcr, m_ifr, m_ier, m_sr;
   logic [3:0]  m_lines;

   typedef struct packed {
      logic [7:0] rdata;
      logic [7:0] drive_a;
      logic [7:0] drive_b;
      logic       irq;
      logic       ca2;
      logic       cb2;
      logic       ca2_stb;
      logic       cb2_stb;
   } rsp_beat_type;

   rsp_beat_type expected_rsp_q[$];
   int  errors = 0;
   int  n_sent = 0;
   int  n_checked = 0;
   bit  idle_en = 1'b1;    // random gaps on both sides
   int  hold_off = 0;      // long receiver stall, in cycles
   int  rsp_gap = 0;       // remaining cycles of a short receiver stall

   function automatic int wrap18(int v);
      logic [17:0] u;
      u = v[17:0];
      return u[17] ? int'(u) - 32'h40000 : int'(u);
   endfunction

   function automatic void shadow_reset();
      m_out_a = 8'hFF; m_out_b = 8'hFF; m_dir_a = 8'hFF; m_dir_b = 8'hFF;
      m_lat_a = '0; m_lat_b = '0;
      m_cnt1 = 32'hFFFF; m_cnt2 = 32'hFFFF;
      m_rel1 = 16'hFFFF; m_rel2 = 16'hFFFF;
      m_done1 = 1'b1; m_done2 = 1'b1;
      m_acr = '0; m_pcr = '0; m_ifr = '0; m_ier = '0; m_sr = '0; m_lines = '0;
   endfunction

   function automatic void irq_eval();
      m_ifr[7] = |(m_ifr[6:0] & m_ier[6:0]);
   endfunction

   function automatic void clr_a_flags();
      m_ifr[via_pkg::FLAG_CA1] = 1'b0;
      if ((m_pcr & 8'h0A) != 8'h02) m_ifr[via_pkg::FLAG_CA2] = 1'b0;
   endfunction

   function automatic void clr_b_flags();
      m_ifr[via_pkg::FLAG_CB1] = 1'b0;
      if ((m_pcr & 8'hA0) != 8'h20) m_ifr[via_pkg::FLAG_CB2] = 1'b0;
   endfunction

   function automatic void run_timers(logic [11:0] t);
      int per, gap, k;
      m_cnt1 = wrap18(m_cnt1 - int'(t));
      m_cnt2 = wrap18(m_cnt2 - int'(t));
      if (m_cnt1 < -3) begin
         per = int'(m_rel1) + 2;
         gap = -1 - m_cnt1;
         k = (gap + per - 1) / per;
         m_cnt1 = wrap18(m_cnt1 + k * per);
         if (!m_done1) m_ifr[via_pkg::FLAG_T1] = 1'b1;
         if (m_acr[7] && !m_done1) m_out_b[7] = ~m_out_b[7];
         if (!m_acr[6]) m_done1 = 1'b1;
      end
      if (!m_acr[5] && m_cnt2 < -1 && !m_done2) begin
         m_ifr[via_pkg::FLAG_T2] = 1'b1;
         m_done2 = 1'b1;
      end
   endfunction

   function automatic void line_event(logic [1:0] sel, logic lv,
                                      logic [7:0] pa, logic [7:0] pb);
      if (lv == m_lines[sel]) return;
      case (sel)
         2'd0: if (m_pcr[0] == lv) begin
            if (m_acr[0]) m_lat_a = pa;
            m_ifr[via_pkg::FLAG_CA1] = 1'b1;
            if ((m_pcr & 8'h0C) == 8'h08) m_lines[1] = 1'b1;
         end
         2'd1: begin
            if (m_pcr[3]) return;
            if (m_pcr[2] == lv) m_ifr[via_pkg::FLAG_CA2] = 1'b1;
         end
         2'd2: if (m_pcr[4] == lv) begin
            if (m_acr[1]) m_lat_b = pb;
            m_ifr[via_pkg::FLAG_CB1] = 1'b1;
            if ((m_pcr & 8'hC0) == 8'h80) m_lines[3] = 1'b1;
         end
         default: begin
            if (m_pcr[7]) return;
            if (m_pcr[6] == lv) m_ifr[via_pkg::FLAG_CB2] = 1'b1;
         end
      endcase
      m_lines[sel] = lv;
   endfunction

   function automatic void reg_write(logic [3:0] a, logic [7:0] v,
                                     inout logic sa, inout logic sb);
      case (a)
         via_pkg::REG_ORB: begin
            clr_b_flags();
            m_out_b = v;
            if ((m_pcr & 8'hE0) == 8'h80) m_lines[3] = 1'b0;
            if ((m_pcr & 8'hE0) == 8'hA0) begin sb = 1'b1; m_lines[3] = 1'b1; end
         end
         via_pkg::REG_ORA: begin
            clr_a_flags();
            if ((m_pcr & 8'h0E) == 8'h08) m_lines[1] = 1'b0;
            if ((m_pcr & 8'h0E) == 8'h0A) begin sa = 1'b1; m_lines[1] = 1'b1; end
            m_out_a = v;
         end
         via_pkg::REG_ORA_NH: m_out_a = v;
         via_pkg::REG_DDRB: m_dir_b = v;
         via_pkg::REG_DDRA: m_dir_a = v;
         via_pkg::REG_T1CL, via_pkg::REG_T1LL: m_rel1[7:0] = v;
         via_pkg::REG_T1LH: begin
            m_rel1[15:8] = v;
            if (m_acr[6]) m_ifr[via_pkg::FLAG_T1] = 1'b0;
         end
         via_pkg::REG_T1CH: begin
            if ((m_acr & 8'hC0) == 8'h80) m_out_b[7] = 1'b0;
            m_rel1[15:8] = v;
            m_cnt1 = int'(m_rel1) + 1;
            m_done1 = 1'b0;
            m_ifr[via_pkg::FLAG_T1] = 1'b0;
         end
         via_pkg::REG_T2CL: m_rel2[7:0] = v;
         via_pkg::REG_T2CH: begin
            m_rel2[15:8] = v;
            m_cnt2 = int'(m_rel2) + 1;
            m_ifr[via_pkg::FLAG_T2] = 1'b0;
            m_done2 = 1'b0;
         end
         via_pkg::REG_SR:  m_sr = v;
         via_pkg::REG_ACR: m_acr = v;
         via_pkg::REG_PCR: begin
            m_pcr = v;
            if ((v & 8'h0E) == 8'h0C) m_lines[1] = 1'b0;
            else if (v[3]) m_lines[1] = 1'b1;
            if ((v & 8'hE0) == 8'hC0) m_lines[3] = 1'b0;
            else if (v[7]) m_lines[3] = 1'b1;
         end
         via_pkg::REG_IFR: m_ifr = m_ifr & ~{1'b0, v[6:0]};
         default: begin   // IER: bit 7 picks set or clear
            if (v[7]) m_ier = m_ier | {1'b0, v[6:0]};
            else      m_ier = m_ier & ~{1'b0, v[6:0]};
         end
      endcase
   endfunction

   function automatic logic [7:0] reg_read(logic [3:0] a, logic [7:0] pa,
                                           logic [7:0] pb);
      logic [17:0] c1, c2;
      logic [7:0]  src;
      c1 = m_cnt1[17:0];
      c2 = m_cnt2[17:0];
      case (a)
         via_pkg::REG_ORA, via_pkg::REG_ORA_NH: begin
            if (a == via_pkg::REG_ORA) begin clr_a_flags(); irq_eval(); end
            src = m_acr[0] ? m_lat_a : pa;
            return (m_out_a & m_dir_a) | (src & ~m_dir_a);
         end
         via_pkg::REG_ORB: begin
            clr_b_flags();
            src = m_acr[1] ? m_lat_b : pb;
            return (m_out_b & m_dir_b) | (src & ~m_dir_b);
         end
         via_pkg::REG_DDRB: return m_dir_b;
         via_pkg::REG_DDRA: return m_dir_a;
         via_pkg::REG_T1LL: return m_rel1[7:0];
         via_pkg::REG_T1LH: return m_rel1[15:8];
         via_pkg::REG_T1CL: begin
            m_ifr[via_pkg::FLAG_T1] = 1'b0;
            return (m_cnt1 < -1) ? 8'hFF : c1[7:0];
         end
         via_pkg::REG_T1CH: return (m_cnt1 < -1) ? 8'hFF : c1[15:8];
         via_pkg::REG_T2CL: begin
            m_ifr[via_pkg::FLAG_T2] = 1'b0;
            return c2[7:0];
         end
         via_pkg::REG_T2CH: return c2[15:8];
         via_pkg::REG_SR:   return m_sr;
         via_pkg::REG_ACR:  return m_acr;
         via_pkg::REG_PCR:  return m_pcr;
         via_pkg::REG_IFR:  return m_ifr;
         default:           return m_ier | 8'h80;
      endcase
   endfunction

   // Applies one event to the shadow registers and gives the response beat.
   function automatic rsp_beat_type apply_event(via_pkg::func_type f,
         logic [3:0] a, logic [7:0] wd, logic [11:0] el, logic [1:0] sel,
         logic lv, logic [7:0] pa, logic [7:0] pb);
      rsp_beat_type r;
      logic sa, sb;
      sa = 1'b0; sb = 1'b0;
      r = '0;
      case (f)
         via_pkg::FUNC_WRITE: reg_write(a, wd, sa, sb);
         via_pkg::FUNC_READ:  r.rdata = reg_read(a, pa, pb);
         via_pkg::FUNC_TICK:  run_timers(el);
         default:             line_event(sel, lv, pa, pb);
      endcase
      irq_eval();
      r.irq     = m_ifr[7];
      r.drive_a = (m_out_a & m_dir_a) | ~m_dir_a;
      r.drive_b = (m_out_b & m_dir_b) | ~m_dir_b;
      r.ca2     = m_lines[1];
      r.cb2     = m_lines[3];
      r.ca2_stb = sa;
      r.cb2_stb = sb;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Sender: one beat per call; valid is deasserted once the beat is accepted,
   // and a random gap may precede the next beat if idling
   // ---------------------------------------------------------------------
   task automatic send_event(via_pkg::func_type f, logic [3:0] a,
         logic [7:0] wd, logic [11:0] el, logic [1:0] sel, logic lv,
         logic [7:0] pa, logic [7:0] pb);
      int gap;
      @(posedge clock);
      if (idle_en && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {6'd0, pb, pa, el, wd, a, f};
      req_tuser  <= {lv, sel};
      req_tvalid <= 1'b1;
      expected_rsp_q.push_back(apply_event(f, a, wd, el, sel, lv, pa, pb));
      do @(posedge clock); while (!req_tready);
      req_tvalid <= 1'b0;
      n_sent++;
   endtask

   task automatic wr(logic [3:0] a, logic [7:0] v);
      send_event(via_pkg::FUNC_WRITE, a, v, 12'($urandom), 2'($urandom),
                 1'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic rd(logic [3:0] a);
      send_event(via_pkg::FUNC_READ, a, 8'($urandom), 12'($urandom),
                 2'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic tk(logic [11:0] n);
      send_event(via_pkg::FUNC_TICK, 4'($urandom), 8'($urandom), n,
                 2'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic ln(logic [1:0] sel, logic lv);
      send_event(via_pkg::FUNC_LINE, 4'($urandom), 8'($urandom),
                 12'($urandom), sel, lv, 8'($urandom), 8'($urandom));
   endtask

   // Pause until every response is back.
   task automatic drain();
      while (expected_rsp_q.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Receiver: random stall bursts while idling is enabled, plus a long hold-off
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off   <= hold_off - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap    <= rsp_gap - 1;
         rsp_tready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
         rsp_gap    <= $urandom_range(0, 6);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Checker: every accepted response beat against the oldest expectation.
   always @(posedge clock) begin
      rsp_beat_type exp_b, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '0;
         got.rdata   = rsp_tdata[7:0];
         got.drive_a = rsp_tdata[15:8];
         got.drive_b = rsp_tdata[23:16];
         got.irq     = rsp_tuser[0];
         got.ca2     = rsp_tuser[1];
         got.cb2     = rsp_tuser[2];
         got.ca2_stb = rsp_tuser[3];
         got.cb2_stb = rsp_tuser[4];
         if (expected_rsp_q.size() == 0) begin
            $display("%0t: unexpected response beat %h", $time, got);
            errors++;
         end else begin
            exp_b = expected_rsp_q.pop_front();
            n_checked++;
            if (got.rdata !== exp_b.rdata) begin
               $display("%0t: rdata exp %h got %h", $time, exp_b.rdata, got.rdata);
               errors++;
            end
            if (got.drive_a !== exp_b.drive_a) begin
               $display("%0t: drive_a exp %h got %h", $time, exp_b.drive_a,
                        got.drive_a);
               errors++;
            end
            if (got.drive_b !== exp_b.drive_b) begin
               $display("%0t: drive_b exp %h got %h", $time, exp_b.drive_b,
                        got.drive_b);
               errors++;
            end
            if (got.irq !== exp_b.irq) begin
               $display("%0t: irq exp %b got %b", $time, exp_b.irq, got.irq);
               errors++;
            end
            if (got.ca2 !== exp_b.ca2) begin
               $display("%0t: ca2_out exp %b got %b", $time, exp_b.ca2, got.ca2);
               errors++;
            end
            if (got.cb2 !== exp_b.cb2) begin
               $display("%0t: cb2_out exp %b got %b", $time, exp_b.cb2, got.cb2);
               errors++;
            end
            if (got.ca2_stb !== exp_b.ca2_stb) begin
               $display("%0t: ca2_strobe exp %b got %b", $time, exp_b.ca2_stb,
                        got.ca2_stb);
               errors++;
            end
            if (got.cb2_stb !== exp_b.cb2_stb) begin
               $display("%0t: cb2_strobe exp %b got %b", $time, exp_b.cb2_stb,
                        got.cb2_stb);
               errors++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset values of all registers, then writes to the direction, port A, SR, IER and ACR registers with read-backs.
   task automatic test_registers();
      for (int a = 0; a < 16; a++) rd(a[3:0]);
      wr(via_pkg::REG_DDRA, 8'h00); wr(via_pkg::REG_DDRB, 8'h0F);
      wr(via_pkg::REG_ORA_NH, 8'hA5); wr(via_pkg::REG_SR, 8'hFF);
      rd(via_pkg::REG_SR);
      wr(via_pkg::REG_IER, 8'hFF); rd(via_pkg::REG_IER);
      wr(via_pkg::REG_IER, 8'h7F);
      wr(via_pkg::REG_ACR, 8'h03); rd(via_pkg::REG_ORA); rd(via_pkg::REG_ORB);
   endtask

   // Timer 1 one-shot, free-run with PB7 toggle and short-period reload;
   // count read while reloading; timer 2 wrap and pulse-count inhibit.
   task automatic test_timers();
      wr(via_pkg::REG_IER, 8'hE0);
      wr(via_pkg::REG_ACR, 8'h00); wr(via_pkg::REG_T1CL, 8'h03);
      wr(via_pkg::REG_T1CH, 8'h00);
      tk(12'd5); rd(via_pkg::REG_T1CL); rd(via_pkg::REG_T1CH); tk(12'd1);
      wr(via_pkg::REG_ACR, 8'hC0); wr(via_pkg::REG_T1CL, 8'h00);
      wr(via_pkg::REG_T1CH, 8'h00);
      tk(12'hFFF); rd(via_pkg::REG_T1CH); rd(via_pkg::REG_IFR);
      rd(via_pkg::REG_T1CL);
      wr(via_pkg::REG_T1LH, 8'h01); tk(12'd2);
      wr(via_pkg::REG_T2CL, 8'h00); wr(via_pkg::REG_T2CH, 8'h00);
      tk(12'hFFF); rd(via_pkg::REG_T2CL);
      rd(via_pkg::REG_T2CH);
      for (int i = 0; i < 70; i++) tk(12'hFFF);   // wrap timer 2 count
      rd(via_pkg::REG_T2CH);
      wr(via_pkg::REG_ACR, 8'h20); wr(via_pkg::REG_T2CH, 8'h00); tk(12'd9);
      rd(via_pkg::REG_IFR);
   endtask

   // Control lines: input edges, output lines ignored, handshake/pulse modes.
   task automatic test_lines();
      wr(via_pkg::REG_IER, 8'h9B); wr(via_pkg::REG_ACR, 8'h03);
      wr(via_pkg::REG_PCR, 8'h00); ln(2'd0, 1'b1); ln(2'd0, 1'b0);
      ln(2'd0, 1'b0);
      wr(via_pkg::REG_PCR, 8'h55); ln(2'd0, 1'b1); ln(2'd1, 1'b1);
      ln(2'd2, 1'b1);
      ln(2'd3, 1'b1); rd(via_pkg::REG_IFR); rd(via_pkg::REG_ORA);
      rd(via_pkg::REG_ORB);
      wr(via_pkg::REG_PCR, 8'h22); ln(2'd1, 1'b0); wr(via_pkg::REG_ORA, 8'h11);
      rd(via_pkg::REG_IFR);
      wr(via_pkg::REG_PCR, 8'h88); wr(via_pkg::REG_ORA, 8'h01);
      wr(via_pkg::REG_ORB, 8'h02);
      ln(2'd0, 1'b1); ln(2'd0, 1'b0); ln(2'd2, 1'b0); ln(2'd1, 1'b0);
      wr(via_pkg::REG_PCR, 8'hAA); wr(via_pkg::REG_ORA, 8'h03);
      wr(via_pkg::REG_ORB, 8'h04);
      wr(via_pkg::REG_PCR, 8'hCC); ln(2'd3, 1'b0); wr(via_pkg::REG_PCR, 8'hEE);
      wr(via_pkg::REG_IFR, 8'h7F); rd(via_pkg::REG_IFR);
   endtask

   // Long receiver stall while requests keep coming, then a full drain.
   task automatic test_backpressure();
      drain();
      hold_off = 60;
      for (int i = 0; i < 8; i++) rd(4'($urandom_range(0, 15)));
      drain();
   endtask

   task automatic random_event();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40)
         send_event(via_pkg::FUNC_WRITE, 4'($urandom), 8'($urandom),
                    12'($urandom), 2'($urandom), 1'($urandom), 8'($urandom),
                    8'($urandom));
      else if (pick < 65)
         send_event(via_pkg::FUNC_READ, 4'($urandom), 8'($urandom),
                    12'($urandom), 2'($urandom), 1'($urandom), 8'($urandom),
                    8'($urandom));
      else if (pick < 80)
         // mostly short ticks, sometimes a full-range random one
         send_event(via_pkg::FUNC_TICK, 4'($urandom), 8'($urandom),
                    12'(($urandom_range(0, 7) == 0) ? $urandom
                                                   : $urandom_range(0, 40)),
                    2'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
      else
         send_event(via_pkg::FUNC_LINE, 4'($urandom), 8'($urandom),
                    12'($urandom), 2'($urandom), 1'($urandom), 8'($urandom),
                    8'($urandom));
   endtask

   // Random mix with short timer periods so reloads and flags keep firing.
   task automatic test_random(int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 29) == 0) begin
            wr(via_pkg::REG_T1CL, 8'($urandom_range(0, 20)));
            wr(via_pkg::REG_T1CH, 8'h00);
            wr(via_pkg::REG_T2CL, 8'($urandom_range(0, 20)));
            wr(via_pkg::REG_T2CH, 8'h00);
         end else begin
            random_event();
         end
      end
   endtask

   initial begin
      shadow_reset();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_registers();
      test_timers();
      test_lines();
      test_backpressure();
      test_random(190);
      idle_en = 1'b0;       // closing stretch at full rate
      test_random(70);
      drain();
      repeat (20) @(posedge clock);
      $display("Sent %0d events, checked %0d responses: registers, timers,",
               n_sent, n_checked);
      $display("control lines, stalls and random traffic.");
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #100ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule
`default_nettype wire

>>> sim.f
sv/via_pkg.sv
sv/via_ctrl.sv
sv/via_dp.sv
sv/versatile_interface_adapter.sv
dv/versatile_interface_adapter_tb.sv
